@@ design/bounded_stable_priority_queue_macros.svh @@
// Assertion macros used by the priority queue top-level design file.
`ifndef BOUNDED_STABLE_PRIORITY_QUEUE_MACROS_SVH
`define BOUNDED_STABLE_PRIORITY_QUEUE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define BSPQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define BSPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/bspq_pkg.sv @@
// Shared types and constants for the sorted priority queue.
package bspq_pkg;

  localparam int KEY_W       = 32;
  localparam int PAY_W       = 64;
  localparam int DEF_CAPACITY = 128;

  // Request operation codes
  localparam logic OP_INSERT  = 1'b0;
  localparam logic OP_EXTRACT = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // Contents of one cell of the sorted row
  typedef struct packed {
    logic                    valid;
    logic signed [KEY_W-1:0] key;
    logic [PAY_W-1:0]        payload;
  } entry_t;

  // Command broadcast to every cell
  typedef struct packed {
    logic                    ins;
    logic                    ext;
    logic signed [KEY_W-1:0] key;
    logic [PAY_W-1:0]        payload;
  } cmd_t;

endpackage

@@ design/bounded_stable_priority_queue.sv @@
// Bounded min-first priority queue built as a row of shifting cells.
// Each request is an insert (func 0) or an extract of the smallest key
// (func 1); equal keys leave in arrival order. The row of CAPACITY cells
// updates once per request: every cell compares its key with
// the incoming one and either holds, shifts from its left neighbor, or
// takes the new entry; extract shifts every cell one place left. One
// request is taken per cycle, and its result appears in the output
// register on the next cycle; the output register stalls the input only
// when a result is waiting and out_stall is high. Inserting into a full
// queue returns status 1, extracting from an empty one returns status 2,
// both with out_payload zero. No clearing pass is needed after reset.
`include "bounded_stable_priority_queue_macros.svh"

module bounded_stable_priority_queue
  import bspq_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    func,
  input  logic signed [KEY_W-1:0] key,
  input  logic [PAY_W-1:0]        payload,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [1:0]              status,
  output logic [PAY_W-1:0]        out_payload
);

  entry_t              q     [CAPACITY];
  logic [CAPACITY-1:0] gt;
  logic [CAPACITY-1:0] vld;
  logic [CAPACITY:0]   vld_inc;
  cmd_t                cmd;
  logic                accept;
  logic                full;
  logic                empty;
  logic                out_valid_next;
  logic [1:0]          status_next;
  logic [PAY_W-1:0]    out_payload_next;

  // Handshake and occupancy
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;
  assign full     = q[CAPACITY-1].valid;
  assign empty    = !q[0].valid;

  // Command to the row, only for requests that change the state
  assign cmd.ins     = accept && (func == OP_INSERT) && !full;
  assign cmd.ext     = accept && (func == OP_EXTRACT) && !empty;
  assign cmd.key     = key;
  assign cmd.payload = payload;

  // Row of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t left_q;
    entry_t right_q;
    logic   left_gt;

    // Head cell has nothing to its left: it is the insert point when behind
    if (i == 0) begin : g_head
      assign left_q  = '0;
      assign left_gt = 1'b0;
    end else begin : g_mid
      assign left_q  = q[i-1];
      assign left_gt = gt[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_q = '0;
    end else begin : g_body
      assign right_q = q[i+1];
    end

    bspq_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .cmd     (cmd),
      .left_q  (left_q),
      .left_gt (left_gt),
      .right_q (right_q),
      .gt      (gt[i]),
      .q       (q[i])
    );

    assign vld[i] = q[i].valid;
  end

  // Result for the accepted request
  always_comb begin
    status_next      = ST_OK;
    out_payload_next = '0;
    if (func == OP_INSERT) begin
      if (full) begin
        status_next = ST_FULL;
      end
    end else if (empty) begin
      status_next = ST_EMPTY;
    end else begin
      out_payload_next = q[0].payload;
    end
  end

  assign out_valid_next = accept || (out_valid && out_stall);

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status      <= status_next;
      out_payload <= out_payload_next;
    end
  end

  // Valid cells form a prefix of the row
  assign vld_inc = {1'b0, vld} + {{CAPACITY{1'b0}}, 1'b1};

  `BSPQ_ASSERT_NOW(a_valid_prefix, 1'b1, $onehot(vld_inc), "valid cells not contiguous")
  `BSPQ_ASSERT_NEXT(a_empty_status, accept && (func == OP_EXTRACT) && empty, out_valid && (status == ST_EMPTY) && (out_payload == '0), "empty extract result wrong")
  `BSPQ_ASSERT_NEXT(a_full_hold, accept && (func == OP_INSERT) && full, (vld == $past(vld)) && (status == ST_FULL), "full insert changed row")

  for (genvar j = 1; j < CAPACITY; j++) begin : g_order_chk
    `BSPQ_ASSERT_NOW(a_sorted, q[j].valid, q[j-1].key <= q[j].key, "row out of key order")
  end

endmodule

@@ design/bspq_cell.sv @@
// One cell of the sorted row: holds an entry and shifts with its neighbors.
module bspq_cell
  import bspq_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  cmd_t   cmd,
  input  entry_t left_q,
  input  logic   left_gt,
  input  entry_t right_q,
  output logic   gt,
  output entry_t q
);

  entry_t q_next;

  // Cell is behind the insert point: empty or strictly larger key
  assign gt = !q.valid || (q.key > cmd.key);

  // Insert: shift right from the insert point; extract: shift left
  always_comb begin
    q_next = q;
    if (cmd.ins) begin
      if (gt) begin
        if (left_gt) begin
          q_next = left_q;
        end else begin
          q_next.valid   = 1'b1;
          q_next.key     = cmd.key;
          q_next.payload = cmd.payload;
        end
      end
    end else if (cmd.ext) begin
      q_next = right_q;
    end
  end

  // Valid flag is control state
  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else begin
      q.valid <= q_next.valid;
    end
  end

  // Key and payload need no reset
  always_ff @(posedge clk) begin
    q.key     <= q_next.key;
    q.payload <= q_next.payload;
  end

endmodule

@@ dv/bounded_stable_priority_queue_tb.sv @@
// Self-checking testbench for the bounded stable min-first priority queue.
module bounded_stable_priority_queue_tb;
  import bspq_pkg::*;

  // One request as it goes into the block
  typedef struct packed {
    logic                    func;
    logic signed [KEY_W-1:0] key;
    logic [PAY_W-1:0]        payload;
  } request_t;

  // One result as the block should return it
  typedef struct packed {
    logic [1:0]       status;
    logic [PAY_W-1:0] payload;
  } result_t;

  // One stored entry of the predicted queue
  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [PAY_W-1:0]        payload;
  } slot_t;

  // Idle and stall pattern of the two channels
  typedef enum int {FLOW_FREE, FLOW_SRC_IDLE, FLOW_SINK_STALL, FLOW_BOTH} flow_e;

  localparam int HOLD_CYCLES = 300;
  localparam int MAX_PRINTS  = 40;

  logic                    clk;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic                    func = OP_INSERT;
  logic signed [KEY_W-1:0] key = '0;
  logic [PAY_W-1:0]        payload = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [1:0]              status;
  logic [PAY_W-1:0]        out_payload;

  request_t req_backlog[$];
  result_t  due_results[$];
  slot_t    sorted_entries[$];

  flow_e flow = FLOW_FREE;
  bit    hold_go = 1'b0;
  bit    sink_hold = 1'b0;

  int err_count = 0;
  int n_ins = 0, n_ext = 0, n_full = 0, n_empty = 0, n_checked = 0;
  result_t got_exp;

  bounded_stable_priority_queue #(
    .CAPACITY(DEF_CAPACITY)
  ) u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .func       (func),
    .key        (key),
    .payload    (payload),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .out_payload(out_payload)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
  end

  // Print one line per mismatch (capped) and count it
  task automatic log_mismatch(string what);
    if (err_count < MAX_PRINTS) $display("ERROR @%0t: %s", $realtime, what);
    err_count++;
  endtask

  // Apply one accepted request to the predicted queue, queue its result
  function automatic void pq_apply(logic f, logic signed [KEY_W-1:0] k,
                                   logic [PAY_W-1:0] p);
    result_t res;
    slot_t   s;
    int      pos;
    res.status  = ST_OK;
    res.payload = '0;
    if (f == OP_INSERT) begin
      n_ins++;
      if (sorted_entries.size() >= DEF_CAPACITY) begin
        res.status = ST_FULL;
        n_full++;
      end else begin
        // goes behind every entry with an equal or smaller key
        pos = 0;
        while (pos < sorted_entries.size() && sorted_entries[pos].key <= k) pos++;
        s.key     = k;
        s.payload = p;
        sorted_entries.insert(pos, s);
      end
    end else begin
      n_ext++;
      if (sorted_entries.size() == 0) begin
        res.status = ST_EMPTY;
        n_empty++;
      end else begin
        res.payload = sorted_entries[0].payload;
        void'(sorted_entries.pop_front());
      end
    end
    due_results.push_back(res);
  endfunction

  function automatic logic signed [KEY_W-1:0] pick_key();
    case ($urandom_range(3))
      0: pick_key = $urandom_range(6) - 3;
      1, 2: pick_key = $urandom;
      default: begin
        case ($urandom_range(3))
          0: pick_key = {1'b1, {(KEY_W-1){1'b0}}};
          1: pick_key = {1'b0, {(KEY_W-1){1'b1}}};
          2: pick_key = '0;
          default: pick_key = '1;
        endcase
      end
    endcase
  endfunction

  function automatic logic [PAY_W-1:0] pick_payload();
    case ($urandom_range(15))
      0: pick_payload = '0;
      1: pick_payload = '1;
      default: pick_payload = {$urandom, $urandom};
    endcase
  endfunction

  task automatic queue_req(logic f, logic signed [KEY_W-1:0] k, logic [PAY_W-1:0] p);
    request_t r;
    r.func    = f;
    r.key     = k;
    r.payload = p;
    req_backlog.push_back(r);
  endtask

  // Random mix; ins_pct steers the queue toward full or empty
  task automatic queue_random(int n, int ins_pct);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < ins_pct) queue_req(OP_INSERT, pick_key(), pick_payload());
      else queue_req(OP_EXTRACT, pick_key(), pick_payload());
    end
  endtask

  // Sender waits until every request is taken and every result is back
  task automatic wait_drained();
    while (req_backlog.size() != 0 || in_valid || due_results.size() != 0)
      @(negedge clk);
  endtask

  // Driver: predict on acceptance, then offer the next request or idle
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) pq_apply(func, key, payload);
      if (!in_valid || !in_stall) begin
        if (req_backlog.size() != 0 &&
            !(flow == FLOW_SRC_IDLE && $urandom_range(99) < 86) &&
            !(flow == FLOW_BOTH && $urandom_range(99) < 8)) begin
          in_valid <= 1'b1;
          func     <= req_backlog[0].func;
          key      <= req_backlog[0].key;
          payload  <= req_backlog[0].payload;
          void'(req_backlog.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall pattern
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (sink_hold) begin
      out_stall <= 1'b1;
    end else begin
      case (flow)
        FLOW_SINK_STALL: out_stall <= ($urandom_range(99) < 86);
        FLOW_BOTH:       out_stall <= ($urandom_range(99) < 8);
        default:         out_stall <= 1'b0;
      endcase
    end
  end

  // Monitor: compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (due_results.size() == 0) begin
        log_mismatch($sformatf("result with none due: status %0d payload %h",
                               status, out_payload));
      end else begin
        got_exp = due_results.pop_front();
        n_checked++;
        if (status !== got_exp.status)
          log_mismatch($sformatf("status %0d, expected %0d", status, got_exp.status));
        if (out_payload !== got_exp.payload)
          log_mismatch($sformatf("out_payload %h, expected %h",
                                 out_payload, got_exp.payload));
      end
    end
  end

  // Long receiver hold-off so the output register fills and stalls the input
  initial begin
    wait (hold_go);
    @(negedge clk);
    sink_hold = 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    sink_hold = 1'b0;
  end

  // Stimulus sequence
  initial begin
    int fill_n;
    @(negedge clk);
    while (rst) @(negedge clk);

    // Directed: empty extract, key extremes, equal keys in arrival order
    queue_req(OP_EXTRACT, '0, '1);
    queue_req(OP_INSERT, {1'b0, {(KEY_W-1){1'b1}}}, '1);
    queue_req(OP_INSERT, {1'b1, {(KEY_W-1){1'b0}}}, '0);
    queue_req(OP_INSERT, '0, 64'h0123_4567_89ab_cdef);
    queue_req(OP_INSERT, '1, 64'h8000_0000_0000_0001);
    queue_req(OP_INSERT, 32'sd5, 64'haaaa_aaaa_aaaa_aaaa);
    queue_req(OP_INSERT, 32'sd5, 64'h5555_5555_5555_5555);
    queue_req(OP_INSERT, 32'sd5, 64'hffff_0000_ffff_0000);
    queue_req(OP_INSERT, '1, 64'h7fff_ffff_ffff_fffe);
    queue_req(OP_EXTRACT, '1, '0);
    queue_req(OP_INSERT, {1'b1, {(KEY_W-1){1'b0}}}, 64'hdead_beef_0bad_f00d);
    for (int i = 0; i < 10; i++) queue_req(OP_EXTRACT, pick_key(), pick_payload());
    wait_drained();

    // Random phases, each flow pattern once, growing then shrinking
    for (int f = 0; f < 4; f++) begin
      flow = flow_e'(f);
      if (f == 0) hold_go = 1'b1;
      queue_random(110, 70);
      wait_drained();
      queue_random(110, 30);
      wait_drained();
    end

    // Fill past capacity, then empty past the last entry
    flow = FLOW_BOTH;
    fill_n = DEF_CAPACITY - sorted_entries.size() + 4;
    for (int i = 0; i < fill_n; i++) queue_req(OP_INSERT, pick_key(), pick_payload());
    wait_drained();
    flow = FLOW_SINK_STALL;
    for (int i = 0; i < DEF_CAPACITY + 3; i++)
      queue_req(OP_EXTRACT, pick_key(), pick_payload());
    wait_drained();

    // let any stray result show up
    repeat (20) @(negedge clk);
    $display("Ran %0d inserts (%0d refused as full) and %0d extracts (%0d on empty),",
             n_ins, n_full, n_ext, n_empty);
    $display("%0d results checked under four flow patterns and a %0d-cycle output hold.",
             n_checked, HOLD_CYCLES);
    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", err_count);
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #1_000_000;
    $display("Timed out with %0d requests and %0d results outstanding",
             req_backlog.size(), due_results.size());
    $display("FAILURE");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+design
design/bspq_pkg.sv
design/bspq_cell.sv
design/bounded_stable_priority_queue.sv
dv/bounded_stable_priority_queue_tb.sv
